>>> rtl/assert_macros.svh
// assertion macros for the nd selection index mapper
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define NSIM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nsim assertion failed");
// condition must never be true outside reset
`define NSIM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("nsim forbidden condition seen");
`else
`define NSIM_ASSERT(lbl, prop)
`define NSIM_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> rtl/nsim_pkg.sv
// shared types and constants of the nd selection index mapper
// no dependencies; used by nsim_div and nd_selection_index_mapper
package nsim_pkg;

  // fixed field geometry of the stream payloads
  localparam int FIELD_DIMS = 4;
  localparam int FIELD_BITS = 16;
  localparam int INDEX_BITS = 32;
  localparam int DATA_BITS  = INDEX_BITS + FIELD_DIMS * FIELD_BITS;
  localparam int OP_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;

  // operation codes carried in tuser
  typedef enum logic [OP_BITS-1:0] {
    OP_REWIND   = 2'd0,
    OP_ADVANCE  = 2'd1,
    OP_TO_COORD = 2'd2,
    OP_TO_INDEX = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIM_COUNT   = 2'd0,
    REG_DIM_STARTS  = 2'd1,
    REG_DIM_EXTENTS = 2'd2,
    REG_DIM_ROLES   = 2'd3
  } cfg_reg_e;

  // dimension roles that take part in counting
  localparam logic [1:0] ROLE_FREE   = 2'd0;
  localparam logic [1:0] ROLE_SELECT = 2'd3;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/nsim_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on nsim_pkg (div_stat_t)
module nsim_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [DVS_W-1:0]   divisor_i,
  output logic [DVD_W-1:0]   quot_o,
  output logic [DVS_W-1:0]   rem_o,
  output nsim_pkg::div_stat_t stat_o
);

  localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] quot_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   rem_nxt;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial   = {rem_q, quot_q[DVD_W-1]};
    ge      = (trial >= {1'b0, dvs_q});
    rem_nxt = ge ? (trial - {1'b0, dvs_q}) : trial;
  end

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DVD_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DVD_W-2:0], ge};
      rem_q  <= rem_nxt[DVS_W-1:0];
    end
  end

  assign quot_o      = quot_q;
  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> rtl/nd_selection_index_mapper.sv
// top level of the nd selection index mapper: odometer, index conversion, config
// depends on nsim_pkg, nsim_div and assert_macros.svh
//
//  channel  | direction | handshake                   | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata index+coords, tuser opcode
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata coords+index, tuser inside,
//           |           |                             | tlast at_end
//  cfg      | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// rewind goes straight to the output state; advance and coordinate-to-index work one
// dimension per step through a shared add/compare or multiply-add unit.
// index-to-coordinates makes one divider pass per counting dimension below the top one,
// on the shared radix-2 divider (32 quotient bits, one per cycle).
// one transaction is worked on at a time; the input is ready only while idle.
// a finished result sits in the output register, so a stalled output only delays the
// handoff of the following result. reset clears config to defaults and the odometer.
module nd_selection_index_mapper #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // flat_index, coord_a, coord_b, coord_c, coord_d (lowest bit up)
  input  logic [nsim_pkg::DATA_BITS-1:0]       s_axis_tdata,
  // opcode
  input  logic [nsim_pkg::OP_BITS-1:0]         s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_coord_a, out_coord_b, out_coord_c, out_coord_d, out_index (lowest bit up)
  output logic [nsim_pkg::DATA_BITS-1:0]       m_axis_tdata,
  // inside_res
  output logic                                 m_axis_tuser,
  // at_end
  output logic                                 m_axis_tlast,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nsim_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [63:0]                          cfg_data_i
);

  localparam int FB    = nsim_pkg::FIELD_BITS;
  localparam int IB    = nsim_pkg::INDEX_BITS;
  localparam int FD    = nsim_pkg::FIELD_DIMS;
  localparam int LANES = 64 / COORD_BITS;
  localparam int ND0   = (MAX_DIMS < FD) ? MAX_DIMS : FD;
  localparam int NDIMS = (ND0 < LANES) ? ND0 : LANES;
  localparam int DIX   = (NDIMS > 1) ? $clog2(NDIMS) : 1;
  localparam int OW    = (COORD_BITS > FB) ? COORD_BITS : FB;
  localparam int VW    = OW + 1;
  localparam int MW    = IB + COORD_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ODO      = 3'd1;
  localparam logic [2:0] ST_DIV_SEL  = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT = 3'd3;
  localparam logic [2:0] ST_IDX      = 3'd4;
  localparam logic [2:0] ST_OUT      = 3'd5;

  // configuration registers
  logic [2:0]  dim_count_q;
  logic [63:0] dim_starts_q;
  logic [63:0] dim_extents_q;
  logic [7:0]  dim_roles_q;

  // sequencer and working registers
  logic [2:0]            state_q, state_d;
  logic [DIX-1:0]        d_q, d_d;
  nsim_pkg::op_e         op_q, op_d;
  logic [IB-1:0]         q_q, q_d;
  logic [IB-1:0]         acc_q, acc_d;
  logic                  ok_q, ok_d;
  logic                  sat_q, sat_d;
  logic                  done_q, done_d;
  logic [COORD_BITS-1:0] odo_q [NDIMS];
  logic [COORD_BITS-1:0] odo_d [NDIMS];
  logic [COORD_BITS-1:0] res_q [NDIMS];
  logic [COORD_BITS-1:0] res_d [NDIMS];
  logic [FB-1:0]         coord_q [NDIMS];
  logic [FB-1:0]         coord_d [NDIMS];

  // output register
  logic                               m_valid_q, m_valid_d;
  logic [nsim_pkg::DATA_BITS-1:0]     m_data_q, m_data_d;
  logic                               m_user_q, m_user_d;
  logic                               m_last_q, m_last_d;

  // per-dimension views of the configuration
  logic [COORD_BITS-1:0] start_w [NDIMS];
  logic [COORD_BITS-1:0] ext_w   [NDIMS];
  logic [NDIMS-1:0]      mask_w;
  logic [NDIMS-1:0]      hi_w;
  logic [2:0]            n_w;

  // shared step unit signals
  logic [COORD_BITS-1:0] s_sel, e_sel;
  logic [COORD_BITS:0]   nxt_w, lim_w;
  logic                  step_hit;
  logic [VW-1:0]         v_w, vlo_w, vhi_w, diff_w;
  logic                  in_rng;
  logic [MW-1:0]         mac_w;

  // divider hookup
  logic                  div_start;
  logic [IB-1:0]         div_quot;
  logic [COORD_BITS-1:0] div_rem;
  nsim_pkg::div_stat_t   div_stat;

  logic [FB-1:0]         out_c_w [FD];
  logic [IB-1:0]         out_idx_w;
  nsim_pkg::op_e         op_in;

  assign op_in = nsim_pkg::op_e'(s_axis_tuser);

  // active dimension count, zero read as one and clamped to what the block holds
  always_comb begin
    if (dim_count_q == 3'd0) begin
      n_w = 3'd1;
    end else if (dim_count_q > 3'(NDIMS)) begin
      n_w = 3'(NDIMS);
    end else begin
      n_w = dim_count_q;
    end
  end

  // start, extent and counting mask of each dimension
  always_comb begin
    for (int d = 0; d < NDIMS; d++) begin
      start_w[d] = dim_starts_q[d*COORD_BITS +: COORD_BITS];
      ext_w[d]   = dim_extents_q[d*COORD_BITS +: COORD_BITS];
      if (ext_w[d] == '0) begin
        ext_w[d] = COORD_BITS'(1);
      end
      mask_w[d] = (3'(d) < n_w) &&
                  ((dim_roles_q[2*d +: 2] == nsim_pkg::ROLE_FREE) ||
                   (dim_roles_q[2*d +: 2] == nsim_pkg::ROLE_SELECT));
    end
  end

  // counting dimensions above each dimension
  always_comb begin
    hi_w[NDIMS-1] = 1'b0;
    for (int d = NDIMS - 2; d >= 0; d--) begin
      hi_w[d] = hi_w[d+1] | mask_w[d+1];
    end
  end

  // shared step unit on the selected dimension
  always_comb begin
    s_sel    = start_w[d_q];
    e_sel    = ext_w[d_q];
    nxt_w    = {1'b0, odo_q[d_q]} + 1'b1;
    lim_w    = {1'b0, s_sel} + {1'b0, e_sel};
    step_hit = mask_w[d_q] && (nxt_w < lim_w);
    v_w      = VW'(coord_q[d_q]);
    vlo_w    = VW'(s_sel);
    vhi_w    = VW'(s_sel) + VW'(e_sel);
    in_rng   = (v_w >= vlo_w) && (v_w < vhi_w);
    diff_w   = v_w - vlo_w;
    mac_w    = MW'(acc_q) * MW'(e_sel) + MW'(diff_w[COORD_BITS-1:0]);
  end

  // result fields as they leave the block
  for (genvar k = 0; k < FD; k++) begin : g_out
    if (k < NDIMS) begin : g_used
      logic [COORD_BITS-1:0] val;
      assign val = ((op_q == nsim_pkg::OP_REWIND) || (op_q == nsim_pkg::OP_ADVANCE)) ?
                   (mask_w[k] ? odo_q[k] : '0) : res_q[k];
      assign out_c_w[k] = FB'(OW'(val));
    end else begin : g_unused
      assign out_c_w[k] = '0;
    end
  end

  assign out_idx_w = (op_q != nsim_pkg::OP_TO_INDEX) ? '0 :
                     ((!ok_q || sat_q) ? '1 : acc_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    d_d       = d_q;
    op_d      = op_q;
    q_d       = q_q;
    acc_d     = acc_q;
    ok_d      = ok_q;
    sat_d     = sat_q;
    done_d    = done_q;
    odo_d     = odo_q;
    res_d     = res_q;
    coord_d   = coord_q;
    div_start = 1'b0;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;

    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = op_in;
          q_d   = s_axis_tdata[IB-1:0];
          acc_d = '0;
          ok_d  = 1'b1;
          sat_d = 1'b0;
          d_d   = '0;
          for (int d = 0; d < NDIMS; d++) begin
            coord_d[d] = s_axis_tdata[IB + d*FB +: FB];
            res_d[d]   = '0;
          end
          unique case (op_in)
            nsim_pkg::OP_REWIND: begin
              for (int d = 0; d < NDIMS; d++) begin
                odo_d[d] = mask_w[d] ? start_w[d] : '0;
              end
              done_d  = 1'b0;
              state_d = ST_OUT;
            end
            nsim_pkg::OP_ADVANCE: begin
              state_d = done_q ? ST_OUT : ST_ODO;
            end
            nsim_pkg::OP_TO_COORD: begin
              state_d = ST_DIV_SEL;
            end
            nsim_pkg::OP_TO_INDEX: begin
              d_d     = DIX'(NDIMS - 1);
              state_d = ST_IDX;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // odometer advance, lowest dimension first
      ST_ODO: begin
        if (step_hit) begin
          odo_d[d_q] = nxt_w[COORD_BITS-1:0];
          for (int r = 0; r < NDIMS; r++) begin
            if ((DIX'(r) < d_q) && mask_w[r]) begin
              odo_d[r] = start_w[r];
            end
          end
          state_d = ST_OUT;
        end else if (d_q == DIX'(NDIMS - 1)) begin
          for (int r = 0; r < NDIMS; r++) begin
            if (mask_w[r]) begin
              odo_d[r] = start_w[r] + ext_w[r];
            end
          end
          done_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          d_d = d_q + 1'b1;
        end
      end

      // index to coordinates, one digit per divider pass
      ST_DIV_SEL: begin
        if (!mask_w[d_q]) begin
          if (d_q == DIX'(NDIMS - 1)) begin
            state_d = ST_OUT;
          end else begin
            d_d = d_q + 1'b1;
          end
        end else if (!hi_w[d_q]) begin
          // top counting dimension takes the whole quotient
          res_d[d_q] = s_sel + q_q[COORD_BITS-1:0];
          state_d    = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end

      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          res_d[d_q] = s_sel + div_rem;
          q_d        = div_quot;
          if (d_q == DIX'(NDIMS - 1)) begin
            state_d = ST_OUT;
          end else begin
            d_d     = d_q + 1'b1;
            state_d = ST_DIV_SEL;
          end
        end
      end

      // coordinates to index, horner form from the top dimension down
      ST_IDX: begin
        if (mask_w[d_q]) begin
          ok_d  = ok_q & in_rng;
          acc_d = mac_w[IB-1:0];
          sat_d = sat_q | (mac_w[MW-1:IB] != '0);
        end
        if (d_q == '0) begin
          state_d = ST_OUT;
        end else begin
          d_d = d_q - 1'b1;
        end
      end

      // hand the result to the output register
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {out_idx_w, out_c_w[3], out_c_w[2], out_c_w[1], out_c_w[0]};
          m_user_d  = (op_q == nsim_pkg::OP_TO_INDEX) && ok_q;
          m_last_d  = done_q;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      d_q       <= '0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
      for (int d = 0; d < NDIMS; d++) begin
        odo_q[d] <= '0;
      end
    end else begin
      state_q   <= state_d;
      d_q       <= d_d;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
      odo_q     <= odo_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    q_q      <= q_d;
    acc_q    <= acc_d;
    ok_q     <= ok_d;
    sat_q    <= sat_d;
    res_q    <= res_d;
    coord_q  <= coord_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q   <= 3'd4;
      dim_starts_q  <= '0;
      dim_extents_q <= 64'h0001_0001_0001_0001;
      dim_roles_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (nsim_pkg::cfg_reg_e'(cfg_index_i))
        nsim_pkg::REG_DIM_COUNT:   dim_count_q   <= cfg_data_i[2:0];
        nsim_pkg::REG_DIM_STARTS:  dim_starts_q  <= cfg_data_i;
        nsim_pkg::REG_DIM_EXTENTS: dim_extents_q <= cfg_data_i;
        nsim_pkg::REG_DIM_ROLES:   dim_roles_q   <= cfg_data_i[7:0];
        default: dim_roles_q <= dim_roles_q;
      endcase
    end
  end

  // shared divider
  nsim_div #(
    .DVD_W(IB),
    .DVS_W(COORD_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(q_q),
    .divisor_i (e_sel),
    .quot_o    (div_quot),
    .rem_o     (div_rem),
    .stat_o    (div_stat)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;
  assign cfg_ready_o   = 1'b1;

  // checks
  `include "assert_macros.svh"

  `NSIM_ASSERT(a_odo_end_sets_done, (state_q == ST_ODO && !step_hit && d_q == DIX'(NDIMS - 1)) |=> done_q)
  `NSIM_ASSERT_NEVER(a_div_start_when_busy, div_start && div_stat.busy)
  `NSIM_ASSERT_NEVER(a_div_done_out_of_wait, div_stat.done && state_q != ST_DIV_WAIT)

endmodule

>>> test/nd_selection_index_mapper_checker.sv
// result checker for the nd selection index mapper: predicts each result and compares it
// watches the input, result and configuration channels; depends on nsim_pkg
module nd_selection_index_mapper_checker
  import nsim_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  // flat_index, coord_a, coord_b, coord_c, coord_d (lowest bit up)
  input  logic [DATA_BITS-1:0]    s_axis_tdata,
  // opcode
  input  logic [OP_BITS-1:0]      s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // out_coord_a, out_coord_b, out_coord_c, out_coord_d, out_index (lowest bit up)
  input  logic [DATA_BITS-1:0]    m_axis_tdata,
  // inside_res
  input  logic                    m_axis_tuser,
  // at_end
  input  logic                    m_axis_tlast,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [63:0]             cfg_data_i,
  output int                      err_cnt_o = 0,
  output int                      pending_o = 0
);

  typedef struct packed {
    logic [FIELD_DIMS-1:0][FIELD_BITS-1:0] coord;
    logic [INDEX_BITS-1:0]                 index;
    logic                                  in_sel;
    logic                                  at_end;
  } mapper_result_t;

  // shadow of the configuration registers
  logic [2:0]  dim_count_q = 3'd4;
  logic [63:0] starts_q    = '0;
  logic [63:0] extents_q   = 64'h0001_0001_0001_0001;
  logic [7:0]  roles_q     = '0;

  // shadow of the odometer
  logic [FIELD_DIMS-1:0][FIELD_BITS-1:0] odo_q = '0;
  logic                                  odo_done_q = 1'b0;

  mapper_result_t expected_q [$];
  int             fail_count = 0;
  string          coord_name [FIELD_DIMS] = '{"out_coord_a", "out_coord_b",
                                              "out_coord_c", "out_coord_d"};

  // dimension count clamped to 1..FIELD_DIMS
  function automatic int unsigned used_dims();
    int unsigned n;
    n = dim_count_q;
    if (n < 1) n = 1;
    if (n > FIELD_DIMS) n = FIELD_DIMS;
    return n;
  endfunction

  function automatic longint unsigned start_at(int d);
    return starts_q[d*FIELD_BITS +: FIELD_BITS];
  endfunction

  // a zero extent counts as one
  function automatic longint unsigned ext_at(int d);
    logic [FIELD_BITS-1:0] e;
    e = extents_q[d*FIELD_BITS +: FIELD_BITS];
    return (e == '0) ? 1 : e;
  endfunction

  function automatic bit is_counting(int d);
    logic [1:0] r;
    r = roles_q[2*d +: 2];
    return (r == ROLE_FREE) || (r == ROLE_SELECT);
  endfunction

  // mixed-radix increment; past the last tuple every counting dim parks at start+extent
  function automatic void step_odometer(int unsigned n);
    longint unsigned nxt;
    bit carry;
    int d;
    carry = 1'b1;
    for (d = 0; d < int'(n) && carry; d++) begin
      if (!is_counting(d)) continue;
      nxt = odo_q[d] + 64'd1;
      if (nxt < start_at(d) + ext_at(d)) begin
        odo_q[d] = nxt[FIELD_BITS-1:0];
        for (int r = 0; r < d; r++)
          if (is_counting(r)) odo_q[r] = start_at(r);
        carry = 1'b0;
      end
    end
    if (carry) begin
      for (d = 0; d < int'(n); d++)
        if (is_counting(d)) odo_q[d] = FIELD_BITS'(start_at(d) + ext_at(d));
      odo_done_q = 1'b1;
    end
  endfunction

  // expected result of one input transaction, updating the odometer shadow
  function automatic mapper_result_t predict_result(op_e op, logic [DATA_BITS-1:0] payload);
    mapper_result_t res;
    int unsigned n;
    int d;
    longint unsigned rem, span, acc, weight, v;
    bit ok;
    res = '0;
    n = used_dims();
    case (op)
      OP_REWIND: begin
        for (d = 0; d < FIELD_DIMS; d++)
          odo_q[d] = (d < int'(n) && is_counting(d)) ? FIELD_BITS'(start_at(d)) : '0;
        odo_done_q = 1'b0;
      end
      OP_ADVANCE: begin
        if (!odo_done_q) step_odometer(n);
      end
      OP_TO_COORD: begin
        rem = payload[INDEX_BITS-1:0];
        span = 1;
        for (d = 0; d < int'(n); d++)
          if (is_counting(d)) span *= ext_at(d);
        // top counting dim keeps the whole remaining quotient
        for (d = int'(n) - 1; d >= 0; d--) begin
          if (!is_counting(d)) continue;
          span = span / ext_at(d);
          if (span == 0) span = 1;
          res.coord[d] = FIELD_BITS'(start_at(d) + rem / span);
          rem = rem % span;
        end
      end
      OP_TO_INDEX: begin
        acc = 0;
        weight = 1;
        ok = 1'b1;
        for (d = 0; d < int'(n); d++) begin
          if (!is_counting(d)) continue;
          v = payload[INDEX_BITS + d*FIELD_BITS +: FIELD_BITS];
          if (v < start_at(d) || v >= start_at(d) + ext_at(d)) begin
            ok = 1'b0;
            break;
          end
          acc += weight * (v - start_at(d));
          weight *= ext_at(d);
        end
        res.in_sel = ok;
        res.index = (!ok || acc > 64'hFFFF_FFFF) ? '1 : acc[INDEX_BITS-1:0];
      end
    endcase
    if (op == OP_REWIND || op == OP_ADVANCE)
      for (d = 0; d < int'(n); d++)
        if (is_counting(d)) res.coord[d] = odo_q[d];
    res.at_end = odo_done_q;
    return res;
  endfunction

  // compare one result transaction with the oldest expectation
  function automatic void check_result(mapper_result_t got);
    mapper_result_t want;
    if (expected_q.size() == 0) begin
      $error("result transaction with no expectation pending");
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    for (int d = 0; d < FIELD_DIMS; d++)
      if (got.coord[d] !== want.coord[d]) begin
        $error("%s: expected %h, got %h", coord_name[d], want.coord[d], got.coord[d]);
        fail_count++;
      end
    if (got.index !== want.index) begin
      $error("out_index: expected %h, got %h", want.index, got.index);
      fail_count++;
    end
    if (got.in_sel !== want.in_sel) begin
      $error("inside_res: expected %b, got %b", want.in_sel, got.in_sel);
      fail_count++;
    end
    if (got.at_end !== want.at_end) begin
      $error("at_end: expected %b, got %b", want.at_end, got.at_end);
      fail_count++;
    end
  endfunction

  // sample all channels at the clock edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dim_count_q = 3'd4;
      starts_q = '0;
      extents_q = 64'h0001_0001_0001_0001;
      roles_q = '0;
      odo_q = '0;
      odo_done_q = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DIM_COUNT:   dim_count_q = cfg_data_i[2:0];
          REG_DIM_STARTS:  starts_q = cfg_data_i;
          REG_DIM_EXTENTS: extents_q = cfg_data_i;
          REG_DIM_ROLES:   roles_q = cfg_data_i[7:0];
        endcase
      end
      if (m_axis_tvalid && m_axis_tready)
        check_result({m_axis_tdata[FIELD_DIMS*FIELD_BITS-1:0],
                      m_axis_tdata[DATA_BITS-1 -: INDEX_BITS], m_axis_tuser, m_axis_tlast});
      if (s_axis_tvalid && s_axis_tready)
        expected_q.insert(expected_q.size(),
                          predict_result(op_e'(s_axis_tuser), s_axis_tdata));
    end
    err_cnt_o <= fail_count;
    pending_o <= expected_q.size();
  end

endmodule

>>> test/nd_selection_index_mapper_tb.sv
// testbench top for the nd selection index mapper: reset, register setups and stimulus
// depends on nsim_pkg, nd_selection_index_mapper and nd_selection_index_mapper_checker
module nd_selection_index_mapper_tb;
  import nsim_pkg::*;

  // display roles, which take no part in counting
  localparam logic [1:0] ROLE_HDISP = 2'd1;
  localparam logic [1:0] ROLE_VDISP = 2'd2;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [DATA_BITS-1:0]    s_axis_tdata;
  logic [OP_BITS-1:0]      s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0]    m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [63:0]             cfg_data;
  int                      mismatches;
  int                      outstanding;

  // stimulus-side copy of the current setup
  logic [2:0]  cur_count  = 3'd4;
  logic [63:0] cur_starts = '0;
  logic [63:0] cur_exts   = 64'h0001_0001_0001_0001;
  logic [7:0]  cur_roles  = '0;

  bit idle_on = 1'b1;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int stall_left = 0;
  int items_sent = 0;
  int setups = 0;
  int op_tally [4] = '{0, 0, 0, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nd_selection_index_mapper u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  nd_selection_index_mapper_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .err_cnt_o     (mismatches),
    .pending_o     (outstanding)
  );

  // result side: long hold on request, short random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < hold_reqs) begin
      m_axis_tready <= 1'b0;
      hold_left <= 249;
      holds_done <= holds_done + 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic bit lane_counts(int d);
    int unsigned n;
    n = (cur_count == 0) ? 1 : (cur_count > FIELD_DIMS) ? FIELD_DIMS : cur_count;
    return (d < int'(n)) &&
           (cur_roles[2*d +: 2] == ROLE_FREE || cur_roles[2*d +: 2] == ROLE_SELECT);
  endfunction

  function automatic int unsigned lane_start(int d);
    return cur_starts[d*FIELD_BITS +: FIELD_BITS];
  endfunction

  function automatic int unsigned lane_ext(int d);
    return (cur_exts[d*FIELD_BITS +: FIELD_BITS] == '0) ? 1 : cur_exts[d*FIELD_BITS +: FIELD_BITS];
  endfunction

  // number of tuples in the selection
  function automatic longint unsigned selection_span();
    longint unsigned span;
    span = 1;
    for (int d = 0; d < FIELD_DIMS; d++)
      if (lane_counts(d)) span *= lane_ext(d);
    return span;
  endfunction

  // one input transaction, with an optional gap ahead of it
  task automatic send_item(input op_e op, input logic [31:0] flat,
                           input logic [FIELD_DIMS-1:0][FIELD_BITS-1:0] crd);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {crd, flat};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    op_tally[op]++;
  endtask

  // one register transaction; valid is left high for the next one
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain all results, then load a full register setup
  task automatic apply_setup(input logic [2:0] cnt, input logic [63:0] starts, exts,
                             input logic [7:0] roles);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_DIM_COUNT, 64'(cnt));
    write_reg(REG_DIM_STARTS, starts);
    write_reg(REG_DIM_EXTENTS, exts);
    write_reg(REG_DIM_ROLES, 64'(roles));
    cfg_valid <= 1'b0;
    cur_count = cnt;
    cur_starts = starts;
    cur_exts = exts;
    cur_roles = roles;
    setups++;
  endtask

  // mostly full odometer walks and in-range conversions, some noise
  task automatic run_phase(input int budget);
    int left, pick, steps;
    longint unsigned span;
    logic [FIELD_DIMS-1:0][FIELD_BITS-1:0] crd;
    logic [31:0] flat, lim;
    left = budget;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      crd = {$urandom, $urandom};
      flat = $urandom;
      span = selection_span();
      if (pick < 4) begin
        steps = (span <= 40) ? int'(span) + $urandom_range(0, 2) : $urandom_range(1, 40);
        send_item(OP_REWIND, flat, crd);
        repeat (steps) send_item(OP_ADVANCE, $urandom, {$urandom, $urandom});
        left -= steps + 1;
      end else if (pick < 6) begin
        lim = (span >= 64'hFFFF_FFF0) ? 32'hFFFF_FFFF : 32'(span + 8);
        if ($urandom_range(0, 4) != 0) flat = $urandom_range(0, lim);
        send_item(OP_TO_COORD, flat, crd);
        left--;
      end else if (pick < 8) begin
        for (int d = 0; d < FIELD_DIMS; d++)
          if ($urandom_range(0, 9) != 0)
            crd[d] = FIELD_BITS'(lane_start(d) + $urandom_range(0, lane_ext(d) - 1));
        send_item(OP_TO_INDEX, flat, crd);
        left--;
      end else begin
        send_item(op_e'($urandom_range(0, 3)), flat, crd);
        left--;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [63:0] starts, exts;
    logic [7:0]  roles;
    rst_n = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_REWIND;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DIM_COUNT;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: one tuple, so the first advance ends the walk
    send_item(OP_REWIND, 32'h0, '0);
    send_item(OP_ADVANCE, 32'hFFFF_FFFF, '1);
    send_item(OP_ADVANCE, 32'h0, '0);
    send_item(OP_TO_COORD, 32'h0, '0);
    send_item(OP_TO_COORD, 32'hFFFF_FFFF, '0);
    send_item(OP_TO_INDEX, 32'h0, '0);
    send_item(OP_TO_INDEX, 32'h0, '1);

    // zero count acts as one, zero extents, starts at the top so the end wraps
    apply_setup(3'd0, '1, '0, 8'hFF);
    send_item(OP_REWIND, 32'h0, '0);
    send_item(OP_ADVANCE, 32'h0, '0);
    send_item(OP_TO_INDEX, 32'h0, {16'h0, 16'h0, 16'h0, 16'hFFFF});
    send_item(OP_TO_COORD, 32'd5, '0);

    // widest selection: index saturates above 32 bits
    apply_setup(3'd4, '0, '1, {ROLE_FREE, ROLE_SELECT, ROLE_FREE, ROLE_SELECT});
    send_item(OP_TO_INDEX, 32'h0, {4{16'hFFFE}});
    send_item(OP_TO_COORD, 32'hFFFF_FFFF, '0);
    send_item(OP_REWIND, 32'h0, '0);
    send_item(OP_ADVANCE, 32'h0, '0);

    // oversized count with only display dims: nothing counts
    apply_setup(3'd7, 64'h1234_5678_9ABC_DEF0, 64'h0003_0003_0003_0003,
                {ROLE_VDISP, ROLE_HDISP, ROLE_VDISP, ROLE_HDISP});
    send_item(OP_REWIND, 32'h0, '0);
    send_item(OP_ADVANCE, 32'h0, '0);
    send_item(OP_TO_COORD, 32'd7, '0);
    send_item(OP_TO_INDEX, 32'h0, {$urandom, $urandom});

    // mixed roles over three dims, one zero extent
    apply_setup(3'd3, 64'h0003_0002_0001_0005, 64'h0004_0003_0000_0002,
                {ROLE_SELECT, ROLE_FREE, ROLE_HDISP, ROLE_SELECT});
    send_item(OP_TO_INDEX, 32'h0, {16'h0, 16'h2, 16'h0, 16'h4});
    send_item(OP_TO_INDEX, 32'h0, {16'h0, 16'h3, 16'h9, 16'h6});
    send_item(OP_TO_COORD, 32'd5, '0);
    send_item(OP_REWIND, 32'h0, '0);
    repeat (7) send_item(OP_ADVANCE, 32'h0, '0);

    // random setups, no idling over the last two
    for (int ph = 0; ph < 13; ph++) begin
      idle_on = (ph >= 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int d = 0; d < FIELD_DIMS; d++) begin
        roles[2*d +: 2] = ($urandom_range(0, 9) < 7) ?
                          ($urandom_range(0, 1) ? ROLE_SELECT : ROLE_FREE) :
                          ($urandom_range(0, 1) ? ROLE_HDISP : ROLE_VDISP);
        starts[d*FIELD_BITS +: FIELD_BITS] = (ph == 0) ? 16'hFFFF :
                                             (ph == 1) ? 16'h0000 : 16'($urandom);
        exts[d*FIELD_BITS +: FIELD_BITS] = ($urandom_range(0, 7) == 0) ?
                                           16'($urandom) : 16'($urandom_range(0, 3));
      end
      apply_setup(3'($urandom_range(0, 7)), starts, exts, roles);
      // result side holds off while the sender keeps offering
      if (ph == 2) hold_reqs++;
      run_phase(55);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transactions over %0d register setups: %0d rewind, %0d advance,",
             items_sent, setups, op_tally[OP_REWIND], op_tally[OP_ADVANCE]);
    $display("  %0d index-to-coordinate and %0d coordinate-to-index conversions",
             op_tally[OP_TO_COORD], op_tally[OP_TO_INDEX]);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
